>>> hdl/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

  // key storage limit and the width of the key length counter
  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_LEN_W     = 9;

  // input action codes
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  // result status codes
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_NO_KEY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD,
    ST_KS_ACC,
    ST_KS_WR1,
    ST_KS_WR2,
    ST_D_RD_I,
    ST_D_RD_J,
    ST_D_SW1,
    ST_D_SW2,
    ST_D_OUT,
    ST_PASS
  } rc4_state_t;

endpackage

>>> hdl/rc4_stream_cipher.sv
`timescale 1ns / 1ps

// rc4 stream cipher, one byte per transaction on each channel
// input channel (in_valid / in_stall): action selects key byte or data byte,
//   last marks the final byte of a key or of a message
// key bytes give no result; the key byte with last starts the key schedule,
//   which sweeps the state table once to identity and then mixes it with
//   the key entry by entry through the read, accumulate and write states;
//   only the first 256 key bytes are kept
// data bytes give one result each on the output channel (out_valid /
//   out_stall): the byte xor the next keystream byte with status ok, or the
//   byte unchanged with status no-key if no complete key has been loaded
// a keyed data byte reads S[i] and S[j], writes the swap, and has its result
//   registered from the result state; a pass-through byte goes straight to
//   the result state; the next transaction is taken only back in idle
// a keyed data byte with last reruns the key schedule from the stored key so the
//   next message restarts the keystream
// in_stall is high whenever the sequencer is busy; a result waits in the
//   output register while out_stall is high, and the sequencer holds in its
//   result state until that register frees up
// reset clears the sequencer, the indices and the key flags; the table and
//   key memories are not cleared

module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       status
);

  rc4_state_t state, state_next;

  // state table and key store
  logic [7:0] sbox [256];
  logic [7:0] key_mem [256];
  logic [7:0] sbox_rdata;
  logic [7:0] key_rdata;

  // table port controls from the sequencer
  logic       sbox_we;
  logic [7:0] sbox_waddr;
  logic [7:0] sbox_wdata;
  logic [7:0] sbox_raddr;

  // key bookkeeping
  logic [KEY_LEN_W-1:0] key_length;
  logic [KEY_LEN_W-1:0] key_len_eff;
  logic                 key_open;
  logic                 keyed;
  logic                 key_we;

  // generator and schedule registers
  logic [7:0] idx_i;
  logic [7:0] idx_j;
  logic [7:0] cnt;
  logic [7:0] acc;
  logic [7:0] kidx;
  logic [7:0] kidx_next;
  logic [7:0] acc_sum;
  logic [7:0] tmp_a;
  logic [7:0] tmp_b;
  logic [7:0] ks_addr;
  logic [7:0] ks;
  logic [7:0] data_reg;
  logic       last_reg;

  logic in_accept;
  logic out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // a new key starts from zero length
  assign key_len_eff = key_open ? key_length : '0;
  assign key_we      = in_accept && (action == ACT_KEY)
                       && (key_len_eff < KEY_LEN_W'(MAX_KEY_BYTES));

  // schedule accumulator: j + S[n] + K[n mod len]
  assign acc_sum = acc + sbox_rdata + key_rdata;

  // key index wraps at the key length (a zero length acts as length one)
  assign kidx_next = (({1'b0, kidx} + 1'b1) >= key_length) ? '0 : kidx + 8'd1;

  // keystream byte: the read in the second swap cycle misses the S[j] write
  assign ks = (ks_addr == idx_j) ? tmp_a : sbox_rdata;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (action == ACT_KEY) begin
            state_next = last ? ST_INIT : ST_IDLE;
          end else begin
            state_next = keyed ? ST_D_RD_I : ST_PASS;
          end
        end
      end
      ST_INIT:   state_next = (cnt == 8'hFF) ? ST_KS_RD : ST_INIT;
      ST_KS_RD:  state_next = ST_KS_ACC;
      ST_KS_ACC: state_next = ST_KS_WR1;
      ST_KS_WR1: state_next = ST_KS_WR2;
      ST_KS_WR2: state_next = (cnt == 8'hFF) ? ST_IDLE : ST_KS_RD;
      ST_D_RD_I: state_next = ST_D_RD_J;
      ST_D_RD_J: state_next = ST_D_SW1;
      ST_D_SW1:  state_next = ST_D_SW2;
      ST_D_SW2:  state_next = ST_D_OUT;
      ST_D_OUT: begin
        if (out_free) begin
          state_next = last_reg ? ST_INIT : ST_IDLE;
        end
      end
      ST_PASS:   state_next = out_free ? ST_IDLE : ST_PASS;
      default:   state_next = ST_IDLE;
    endcase
  end

  // table port controls
  always_comb begin
    sbox_we    = 1'b0;
    sbox_waddr = cnt;
    sbox_wdata = cnt;
    sbox_raddr = cnt;
    unique case (state)
      ST_INIT: begin
        sbox_we = 1'b1;
      end
      ST_KS_ACC: begin
        sbox_raddr = acc_sum;
      end
      ST_KS_WR1: begin
        sbox_we    = 1'b1;
        sbox_wdata = sbox_rdata;
      end
      ST_KS_WR2: begin
        sbox_we    = 1'b1;
        sbox_waddr = acc;
        sbox_wdata = tmp_a;
      end
      ST_D_RD_I: begin
        sbox_raddr = idx_i + 8'd1;
      end
      ST_D_RD_J: begin
        sbox_raddr = idx_j + sbox_rdata;
      end
      ST_D_SW1: begin
        sbox_we    = 1'b1;
        sbox_waddr = idx_i;
        sbox_wdata = sbox_rdata;
      end
      ST_D_SW2: begin
        sbox_we    = 1'b1;
        sbox_waddr = idx_j;
        sbox_wdata = tmp_a;
        sbox_raddr = tmp_a + tmp_b;
      end
      ST_D_OUT: begin
        sbox_raddr = ks_addr;
      end
      default: begin
        sbox_raddr = cnt;
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (sbox_we) begin
      sbox[sbox_waddr] <= sbox_wdata;
    end
    sbox_rdata <= sbox[sbox_raddr];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_len_eff[7:0]] <= data_byte;
    end
    key_rdata <= key_mem[kidx];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      key_length <= '0;
      key_open   <= 1'b0;
      keyed      <= 1'b0;
      idx_i      <= '0;
      idx_j      <= '0;
      cnt        <= '0;
      acc        <= '0;
      kidx       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (in_accept && (action == ACT_KEY)) begin
        key_length <= key_we ? key_len_eff + 1'b1 : key_len_eff;
        key_open   <= !last;
        keyed      <= last;
      end

      unique case (state)
        ST_INIT: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'hFF) begin
            acc  <= '0;
            kidx <= '0;
          end
        end
        ST_KS_ACC: begin
          acc <= acc_sum;
        end
        ST_KS_WR2: begin
          cnt  <= cnt + 8'd1;
          kidx <= kidx_next;
          if (cnt == 8'hFF) begin
            idx_i <= '0;
            idx_j <= '0;
          end
        end
        ST_D_RD_I: begin
          idx_i <= idx_i + 8'd1;
        end
        ST_D_RD_J: begin
          idx_j <= idx_j + sbox_rdata;
        end
        ST_D_OUT: begin
          if (out_free && last_reg) begin
            cnt <= '0;
          end
        end
        default: begin
          if (state == ST_IDLE && in_accept && (action == ACT_KEY) && last) begin
            cnt <= '0;
          end
        end
      endcase

      if ((state == ST_D_OUT || state == ST_PASS) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_reg <= data_byte;
      last_reg <= last;
    end
    if (state == ST_KS_ACC || state == ST_D_RD_J) begin
      tmp_a <= sbox_rdata;
    end
    if (state == ST_D_SW1) begin
      tmp_b <= sbox_rdata;
    end
    if (state == ST_D_SW2) begin
      ks_addr <= tmp_a + tmp_b;
    end
    if (state == ST_D_OUT && out_free) begin
      out_byte <= data_reg ^ ks;
      status   <= STAT_OK;
    end else if (state == ST_PASS && out_free) begin
      out_byte <= data_reg;
      status   <= STAT_NO_KEY;
    end
  end

  // a schedule only ever runs on a stored key
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |-> (keyed && key_length != '0))
    else $error("key schedule started without a stored key");

  // keystream steps only with a scheduled table
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_D_RD_I) |-> keyed)
    else $error("keystream step without a key");

  // the end of a schedule restarts the generator
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_KS_WR2 && cnt == 8'hFF) |=>
      (state == ST_IDLE && idx_i == '0 && idx_j == '0))
    else $error("generator indices not cleared after key schedule");

  // the key index stays inside the stored key
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_KS_RD) |-> (({1'b0, kidx} < key_length) || kidx == '0))
    else $error("key index beyond key length");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rc4_pkg::*;

  // no transaction on either channel for this many cycles ends the run;
  // the slowest correct stretch is a full key schedule plus the longest
  // receiver stall and sender gap, so this is far above it
  localparam int WATCHDOG_LIMIT = 20000;
  // cycles to let the sequencer finish a trailing key schedule at the end
  localparam int SETTLE_CYCLES  = 1500;
  localparam int ITEM_TARGET    = 1650;

  // rc4 keystream predictor and result checker
  class rc4_result_checker;
    typedef struct packed {
      logic [7:0] value;
      logic       stat;
    } expected_t;

    bit [7:0]             perm [256];
    bit [7:0]             key_bytes [256];
    logic [KEY_LEN_W-1:0] key_len;
    logic                 key_open;
    logic                 keyed;
    logic [7:0]           idx_i;
    logic [7:0]           idx_j;
    expected_t            pending_bytes [$];

    int mismatches;
    int keyed_results;
    int passthru_results;
    int keys_scheduled;
    int restarts;
    int longest_key;
    int key_run;

    function new();
      key_len  = '0;
      key_open = 1'b0;
      keyed    = 1'b0;
      idx_i    = '0;
      idx_j    = '0;
      key_run  = 0;
    endfunction

    // identity table mixed with the stored key repeated to 256 bytes
    function void stir_table();
      int unsigned len;
      int          n;
      logic [7:0]  acc;
      logic [7:0]  t;
      len = (key_len == 0) ? 1 : key_len;
      for (n = 0; n < 256; n++) perm[n[7:0]] = n[7:0];
      acc = '0;
      for (n = 0; n < 256; n++) begin
        acc = acc + perm[n[7:0]] + key_bytes[8'(n % len)];
        t = perm[n[7:0]];
        perm[n[7:0]] = perm[acc];
        perm[acc] = t;
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    function void take_input(logic act, logic [7:0] val, logic lst);
      expected_t  e;
      logic [7:0] t;
      logic [7:0] sum;
      if (act == ACT_KEY) begin
        // first key byte after a completed key drops the old one
        if (!key_open) begin
          key_open = 1'b1;
          keyed    = 1'b0;
          key_len  = '0;
          key_run  = 0;
        end
        key_run++;
        if (key_len < MAX_KEY_BYTES) begin
          key_bytes[key_len[7:0]] = val;
          key_len++;
        end
        if (lst) begin
          key_open = 1'b0;
          keyed    = 1'b1;
          keys_scheduled++;
          if (key_run > longest_key) longest_key = key_run;
          stir_table();
        end
        return;
      end
      // no complete key: byte goes through untouched, generator untouched
      if (!keyed) begin
        e.value = val;
        e.stat  = STAT_NO_KEY;
        pending_bytes.push_back(e);
        return;
      end
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      t = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = t;
      sum = perm[idx_i] + perm[idx_j];
      e.value = val ^ perm[sum];
      e.stat  = STAT_OK;
      pending_bytes.push_back(e);
      // end of message restarts the keystream from the stored key
      if (lst) begin
        restarts++;
        stir_table();
      end
    endfunction

    function void check_output(logic [7:0] value, logic stat);
      expected_t e;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result out_byte=%02h status=%0b", $time, value, stat);
        mismatches++;
        return;
      end
      e = pending_bytes.pop_front();
      if (value !== e.value) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, e.value, value);
        mismatches++;
      end
      if (stat !== e.stat) begin
        $display("%0t: status expected %0b actual %0b", $time, e.stat, stat);
        mismatches++;
      end
      if (e.stat == STAT_OK) keyed_results++;
      else passthru_results++;
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction

    function void check_drained();
      if (pending_bytes.size() != 0) begin
        $display("%0t: %0d results expected but never seen, next expected %02h/%0b",
                 $time, pending_bytes.size(), pending_bytes[0].value, pending_bytes[0].stat);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic       action    = ACT_KEY;
  logic [7:0] data_byte = 8'h00;
  logic       last      = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       status;

  rc4_result_checker sb;

  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  always #6 clk = ~clk;

  rc4_stream_cipher u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .data_byte (data_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .status    (status)
  );

  // receiver: switches between free flow, light random stall and heavy stall
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // result monitor: every accepted result transaction is checked in order
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_output(out_byte, status);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one input transaction; the sender runs in bursts with random gaps,
  // and valid stays high across back-to-back transactions in a burst
  task automatic send_item(logic act, logic [7:0] val, logic lst, bit counted = 1'b1);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= val;
    last      <= lst;
    do @(posedge clk); while (in_stall);
    sb.take_input(act, val, lst);
    if (counted) items_sent++;
  endtask

  // drop valid and hold off until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // random key, last on the final byte; bytes past the store limit are dropped
  task automatic send_key(int n_bytes);
    int k;
    for (k = 0; k < n_bytes; k++)
      send_item(ACT_KEY, 8'($urandom_range(0, 255)), k == n_bytes - 1, k < MAX_KEY_BYTES);
  endtask

  task automatic send_message(int n_bytes);
    int k;
    for (k = 0; k < n_bytes; k++)
      send_item(ACT_DATA, 8'($urandom_range(0, 255)), k == n_bytes - 1);
  endtask

  // mostly short keys, a few medium, rarely around and past the limit
  function automatic int pick_key_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 16);
    if (r < 98) return $urandom_range(17, 64);
    return $urandom_range(240, 270);
  endfunction

  // mostly short messages, now and then long enough to wrap index_i
  function automatic int pick_msg_len();
    if ($urandom_range(0, 99) < 95) return $urandom_range(1, 40);
    return $urandom_range(250, 300);
  endfunction

  initial begin
    int choice;
    int n;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // data before any key: passed through, last does not reschedule
    send_item(ACT_DATA, 8'h00, 1'b0);
    send_item(ACT_DATA, 8'hFF, 1'b1);
    // data while a key is still open is also passed through
    send_item(ACT_KEY, 8'h00, 1'b0);
    send_item(ACT_DATA, 8'hA5, 1'b0);
    send_item(ACT_KEY, 8'hFF, 1'b1);
    // keyed data, extremes, end of message restarts the keystream
    send_item(ACT_DATA, 8'h00, 1'b0);
    send_item(ACT_DATA, 8'hFF, 1'b0);
    send_item(ACT_DATA, 8'h5A, 1'b1);
    send_item(ACT_DATA, 8'h00, 1'b0);
    send_item(ACT_DATA, 8'hFF, 1'b1);
    // single byte key
    send_item(ACT_KEY, 8'h80, 1'b1);
    send_item(ACT_DATA, 8'h01, 1'b0);
    send_item(ACT_DATA, 8'h7F, 1'b1);
    // new key replaces the old one rather than extending it
    send_item(ACT_KEY, 8'h01, 1'b0);
    send_item(ACT_KEY, 8'h02, 1'b1);
    send_item(ACT_DATA, 8'h3C, 1'b0);
    send_item(ACT_KEY, 8'h03, 1'b1);
    send_item(ACT_DATA, 8'h3C, 1'b0);
    send_item(ACT_DATA, 8'hC3, 1'b1);
    wait_for_results();

    // key exactly at the store limit, then one running past it
    send_key(MAX_KEY_BYTES);
    send_message(4);
    send_key(MAX_KEY_BYTES + 4);
    send_message(4);

    // random part: mostly key + messages, some noise and broken sequences
    while (items_sent < ITEM_TARGET) begin
      choice = $urandom_range(0, 99);
      if (choice < 80) begin
        if (!sb.keyed || $urandom_range(0, 2) == 0) send_key(pick_key_len());
        n = $urandom_range(1, 3);
        repeat (n) send_message(pick_msg_len());
      end else if (choice < 92) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        // key left open with data arriving before it is closed
        n = $urandom_range(1, 5);
        repeat (n) send_item(ACT_KEY, 8'($urandom_range(0, 255)), 1'b0);
        n = $urandom_range(1, 3);
        repeat (n) send_item(ACT_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 19) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();

    $display("ran %0d input transactions: %0d keys scheduled (longest %0d bytes), %0d restarts",
             items_sent, sb.keys_scheduled, sb.longest_key, sb.restarts);
    $display("checked %0d keyed results and %0d pass-through results",
             sb.keyed_results, sb.passthru_results);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
